FILE: rtl/pde_pkg.sv
// Shared types, constants and saturating helpers for the PV diode parameter estimator.
package pde_pkg;

	localparam int AdcBitsDef     = 16;
	localparam int OutFracBitsDef = 21;

	// ln(2) in Q0.63
	localparam logic [63:0] LN2_Q63 = 64'h58B9_0BFB_E8E7_BCD5;

	// configuration register indexes
	localparam logic [2:0] REG_CURRENT_SCALE = 3'd0;
	localparam logic [2:0] REG_VOLTAGE_SCALE = 3'd1;
	localparam logic [2:0] REG_ISC           = 3'd2;
	localparam logic [2:0] REG_ALPHA_GAIN    = 3'd3;
	localparam logic [2:0] REG_BETA_GAIN     = 3'd4;
	localparam logic [2:0] REG_ALPHA_INIT    = 3'd5;
	localparam logic [2:0] REG_BETA_INIT     = 3'd6;

	// multiplier output shift select
	localparam logic [1:0] SH_31 = 2'd0;
	localparam logic [1:0] SH_47 = 2'd1;
	localparam logic [1:0] SH_48 = 2'd2;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [7:0]         current_scale;
		logic [7:0]         voltage_scale;
		logic [27:0]        isc;
		logic [47:0]        alpha_gain;
		logic [47:0]        beta_gain;
		logic signed [31:0] alpha_init;
		logic signed [31:0] beta_init;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic [1:0]         shsel;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] result;
	} mul_rsp_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	// Q16.48 to Q.F: truncate toward zero, saturate to 32 bits
	function automatic logic [31:0] to_out(input logic signed [63:0] x, input int sh);
		logic [63:0] mag;
		mag = x[63] ? (64'd0 - x) : x;
		mag = mag >> sh;
		if (x[63]) begin
			if (mag > 64'h8000_0000) mag = 64'h8000_0000;
			return 32'(64'd0 - mag);
		end
		if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
		return mag[31:0];
	endfunction

endpackage

FILE: rtl/pv_diode_parameter_estimator_core.sv
// Top level: configuration registers, sequencer and shared multiplier.
//
// Channel   Dir  Handshake              Content
// s_*       in   s_tvalid / s_tready    tdata: voltage, current; tuser: restart
// m_*       out  m_tvalid / m_tready    tdata: alpha, beta, V, I; tuser: log_invalid
// cfg_*     in   cfg_valid / cfg_ready  cfg_index selects register, cfg_data value
//
// A valid item is first normalized, then makes 37 runs of the shared 64x64 multiplier
// (four 32x32 partial products per run, one per cycle), then goes to the output state.
// With current at or above Isc the sequencer goes straight from idle to its output state.
// s_tready is high only while idle; a stalled output holds the sequencer in its output state.
// Reset loads register defaults and the initial estimates.
module pv_diode_parameter_estimator_core #(
	parameter int ADC_BITS      = pde_pkg::AdcBitsDef,
	parameter int OUT_FRAC_BITS = pde_pkg::OutFracBitsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // voltage_sample[15:0], current_sample[31:16]
	input  logic         s_tuser,   // restart
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // alpha[31:0], beta[63:32], voltage[92:64], current[121:93]
	output logic         m_tuser,   // log_invalid
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [47:0]  cfg_data
);
	import pde_pkg::*;

	cfg_t     cfg_q;
	mul_req_t mreq;
	mul_rsp_t mrsp;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_scale <= 8'd5;
			cfg_q.voltage_scale <= 8'd22;
			cfg_q.isc           <= 28'd8367636;
			cfg_q.alpha_gain    <= 48'd28147498;
			cfg_q.beta_gain     <= 48'd28147497671;
			cfg_q.alpha_init    <= 32'sd1153434;
			cfg_q.beta_init     <= -32'sd27262976;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CURRENT_SCALE: cfg_q.current_scale <= cfg_data[7:0];
				REG_VOLTAGE_SCALE: cfg_q.voltage_scale <= cfg_data[7:0];
				REG_ISC:           cfg_q.isc           <= cfg_data[27:0];
				REG_ALPHA_GAIN:    cfg_q.alpha_gain    <= cfg_data;
				REG_BETA_GAIN:     cfg_q.beta_gain     <= cfg_data;
				REG_ALPHA_INIT:    cfg_q.alpha_init    <= cfg_data[31:0];
				REG_BETA_INIT:     cfg_q.beta_init     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	pde_ctrl #(
		.ADC_BITS      (ADC_BITS),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_restart  (s_tuser),
		.in_voltage  (s_tdata[15:0]),
		.in_current  (s_tdata[31:16]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_invalid (m_tuser),
		.mreq        (mreq),
		.mrsp        (mrsp)
	);

	pde_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

endmodule

FILE: rtl/pde_mul.sv
// Shared multicycle signed 64x64 multiplier with truncating shift and saturation.
module pde_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  pde_pkg::mul_req_t req,
	output pde_pkg::mul_rsp_t rsp
);
	import pde_pkg::*;

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [1:0]   shsel_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, fin_q, done_q;
	logic signed [63:0] result_q;

	logic [31:0]  pa, pb;
	logic [63:0]  prod;
	logic [1:0]   offs;
	logic [127:0] shifted;
	logic [63:0]  rlo, limit;
	logic signed [63:0] res_d;

	// one 32x32 partial product per cycle
	assign pa   = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign pb   = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign prod = pa * pb;
	assign offs = 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});

	// final shift, saturate and sign
	always_comb begin
		unique case (shsel_q)
			SH_31:   shifted = acc_q >> 31;
			SH_47:   shifted = acc_q >> 47;
			default: shifted = acc_q >> 48;
		endcase
		rlo   = shifted[63:0];
		limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if (shifted[127:64] != '0 || rlo > limit) res_d = neg_q ? S64_MIN : S64_MAX;
		else if (neg_q) res_d = 64'd0 - rlo;
		else res_d = rlo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operand and accumulator registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q    <= req.a[63] ? (64'd0 - req.a) : req.a;
			ub_q    <= req.b[63] ? (64'd0 - req.b) : req.b;
			neg_q   <= req.a[63] ^ req.b[63];
			shsel_q <= req.shsel;
			acc_q   <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (128'(prod) << {offs, 5'd0});
		end
		if (fin_q) result_q <= res_d;
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

FILE: rtl/pde_ctrl.sv
// Sequencer: scaling, log2 by squaring, error and gradient updates on the shared multiplier.
module pde_ctrl #(
	parameter int ADC_BITS      = pde_pkg::AdcBitsDef,
	parameter int OUT_FRAC_BITS = pde_pkg::OutFracBitsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pde_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_restart,
	input  logic [15:0]       in_voltage,
	input  logic [15:0]       in_current,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [127:0]      out_data,
	output logic              out_invalid,
	output pde_pkg::mul_req_t mreq,
	input  pde_pkg::mul_rsp_t mrsp
);
	import pde_pkg::*;

	localparam int SH_STATE = 48 - OUT_FRAC_BITS;
	localparam int SH_ADC   = OUT_FRAC_BITS - ADC_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_NORM  = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [2:0] STEP_SQ = 3'd0;
	localparam logic [2:0] STEP_LN = 3'd1;
	localparam logic [2:0] STEP_VA = 3'd2;
	localparam logic [2:0] STEP_GV = 3'd3;
	localparam logic [2:0] STEP_DA = 3'd4;
	localparam logic [2:0] STEP_DB = 3'd5;

	logic [2:0]  state_q, step_q;
	logic [4:0]  k_q, p_q;
	logic [31:0] m_q, frac_q;
	logic [31:0] vq_q, iq_q;
	logic        invalid_q;
	logic signed [63:0] alpha_q, beta_q, y_q, e_q, t_q, da_q;
	logic        ovalid_q;
	logic [127:0] odata_q;
	logic        oinv_q;

	logic [ADC_BITS+7:0] vprod, iprod;
	logic [31:0] vq, iq;
	logic signed [33:0] d_full;
	logic        invalid;
	logic signed [63:0] v48, l2, ainit, binit;
	logic [31:0] l2_hi;

	// sample scaling
	assign vprod  = in_voltage[ADC_BITS-1:0] * cfg.voltage_scale;
	assign iprod  = in_current[ADC_BITS-1:0] * cfg.current_scale;
	assign vq     = 32'(vprod) << SH_ADC;
	assign iq     = 32'(iprod) << SH_ADC;
	assign d_full = $signed({6'd0, cfg.isc}) - $signed({2'd0, iq});
	assign invalid = d_full[33] || (d_full == '0);

	assign v48   = 64'(vq_q) << SH_STATE;
	assign ainit = 64'(cfg.alpha_init) <<< SH_STATE;
	assign binit = 64'(cfg.beta_init) <<< SH_STATE;
	assign l2_hi = 32'($signed({27'd0, p_q}) - 32'(OUT_FRAC_BITS));
	assign l2    = {l2_hi, frac_q};

	// operand select for the shared multiplier
	always_comb begin
		mreq.start = (state_q == ST_ISSUE);
		mreq.a     = v48;
		mreq.b     = alpha_q;
		mreq.shsel = SH_48;
		unique case (step_q)
			STEP_SQ: begin
				mreq.a = 64'(m_q);
				mreq.b = 64'(m_q);
				mreq.shsel = SH_31;
			end
			STEP_LN: begin
				mreq.a = l2;
				mreq.b = LN2_Q63;
				mreq.shsel = SH_47;
			end
			STEP_VA: begin
				mreq.a = v48;
				mreq.b = alpha_q;
			end
			STEP_GV: begin
				mreq.a = 64'(cfg.alpha_gain);
				mreq.b = v48;
			end
			STEP_DA: begin
				mreq.a = t_q;
				mreq.b = e_q;
			end
			STEP_DB: begin
				mreq.a = 64'(cfg.beta_gain);
				mreq.b = e_q;
			end
			default: ;
		endcase
	end

	// sequencer and estimate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= STEP_SQ;
			k_q      <= '0;
			p_q      <= '0;
			alpha_q  <= 64'(pde_pkg::S64_MAX & 64'd0) | (64'(32'sd1153434) <<< SH_STATE);
			beta_q   <= 64'(-32'sd27262976) <<< SH_STATE;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_restart) begin
							alpha_q <= ainit;
							beta_q  <= binit;
						end
						state_q <= invalid ? ST_OUT : ST_NORM;
						p_q     <= 5'd31;
					end
				end
				ST_NORM: begin
					if (m_q[31]) begin
						step_q  <= STEP_SQ;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end else begin
						p_q <= p_q - 5'd1;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mrsp.done) begin
						state_q <= ST_ISSUE;
						case (step_q)
							STEP_SQ: begin
								k_q <= k_q + 5'd1;
								if (k_q == 5'd31) step_q <= STEP_LN;
							end
							STEP_LN: step_q <= STEP_VA;
							STEP_VA: step_q <= STEP_GV;
							STEP_GV: step_q <= STEP_DA;
							STEP_DA: step_q <= STEP_DB;
							default: begin
								alpha_q <= sat_add(alpha_q, da_q);
								beta_q  <= sat_add(beta_q, mrsp.result);
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_OUT: begin
					if (!ovalid_q || out_ready) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			vq_q      <= vq;
			iq_q      <= iq;
			invalid_q <= invalid;
			m_q       <= d_full[31:0];
			frac_q    <= '0;
		end
		if (state_q == ST_NORM && !m_q[31]) m_q <= m_q << 1;
		if (state_q == ST_WAIT && mrsp.done) begin
			case (step_q)
				STEP_SQ: begin
					if (mrsp.result[32]) begin
						m_q <= mrsp.result[32:1];
						frac_q[5'd31 - k_q] <= 1'b1;
					end else begin
						m_q <= mrsp.result[31:0];
					end
				end
				STEP_LN: y_q  <= mrsp.result;
				STEP_VA: e_q  <= sat_sub(sat_sub(y_q, mrsp.result), beta_q);
				STEP_GV: t_q  <= mrsp.result;
				STEP_DA: da_q <= mrsp.result;
				default: ;
			endcase
		end
		if (state_q == ST_OUT && (!ovalid_q || out_ready)) begin
			odata_q <= {6'd0, iq_q[28:0], vq_q[28:0],
				to_out(beta_q, SH_STATE), to_out(alpha_q, SH_STATE)};
			oinv_q  <= invalid_q;
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = ovalid_q;
	assign out_data    = odata_q;
	assign out_invalid = oinv_q;

endmodule

FILE: rtl/pde_checker.sv
// Port-level checks for the estimator core, bound to the top level.
module pde_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// the block is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// a new result only appears once the block is idle again
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result issued while busy");

endmodule

bind pv_diode_parameter_estimator_core pde_checker u_pde_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/tb_pv_diode_parameter_estimator_core.sv
// Testbench for the PV diode parameter estimator core: scoreboard class, drivers, checks.

// Scoreboard: predicts estimates and scaled samples, checks results in order
class estimate_scoreboard;
	logic [7:0]         cur_scale, volt_scale;
	logic [27:0]        isc;
	logic [47:0]        a_gain, b_gain;
	logic signed [31:0] a_init, b_init;
	logic signed [63:0] alpha_q48, beta_q48;
	logic [127:0]       pending_data[$];
	logic               pending_flag[$];
	int                 mismatches;

	function new();
		cur_scale  = 8'd5;
		volt_scale = 8'd22;
		isc        = 28'd8367636;
		a_gain     = 48'd28147498;
		b_gain     = 48'd28147497671;
		a_init     = 32'sd1153434;
		b_init     = -32'sd27262976;
		alpha_q48  = 64'(a_init) <<< 27;
		beta_q48   = 64'(b_init) <<< 27;
		mismatches = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [47:0] val);
		case (idx)
			pde_pkg::REG_CURRENT_SCALE: cur_scale = val[7:0];
			pde_pkg::REG_VOLTAGE_SCALE: volt_scale = val[7:0];
			pde_pkg::REG_ISC:           isc = val[27:0];
			pde_pkg::REG_ALPHA_GAIN:    a_gain = val;
			pde_pkg::REG_BETA_GAIN:     b_gain = val;
			pde_pkg::REG_ALPHA_INIT:    a_init = val[31:0];
			pde_pkg::REG_BETA_INIT:     b_init = val[31:0];
			default: ;
		endcase
	endfunction

	// (a*b) >>> s truncated toward zero, saturated to 64 bits
	function logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b, int s);
		logic signed [127:0] p;
		logic [127:0]        mag;
		logic                neg;
		p   = 128'(a) * 128'(b);
		neg = p[127];
		mag = neg ? -p : p;
		mag = mag >> s;
		if (neg) begin
			if (mag > 128'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
			return -64'(mag);
		end
		if (mag > 128'h7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		return 64'(mag);
	endfunction

	function logic signed [63:0] s_add(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function logic signed [63:0] s_sub(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	// natural log of d*2^-21 in Q16.48
	function logic signed [63:0] nat_log(logic [63:0] d);
		int          msb;
		logic [63:0] m, frac;
		logic signed [63:0] l2;
		msb = 0;
		for (int i = 0; i < 64; i++) if (d[i]) msb = i;
		m = d << (31 - msb);
		frac = 0;
		for (int k = 1; k <= 32; k++) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[32 - k] = 1'b1;
			end
		end
		l2 = (64'(msb) - 64'sd21) * 64'sh1_0000_0000 + $signed(frac);
		return fx_mul(l2, 64'sh58B9_0BFB_E8E7_BCD5, 47);
	endfunction

	function logic [31:0] q21_out(logic signed [63:0] x);
		logic [63:0] mag;
		mag = x[63] ? -x : x;
		mag = mag >> 27;
		if (x[63]) begin
			if (mag > 64'h8000_0000) mag = 64'h8000_0000;
			return 32'(-mag);
		end
		if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	// note an accepted input transfer and queue its expected result
	function void note_input(logic restart, logic [15:0] vs, logic [15:0] cs);
		logic [63:0]        vq, iq;
		logic signed [63:0] d, v48, y, e, da;
		logic               bad;
		vq  = (64'(vs) * 64'(volt_scale)) << 5;
		iq  = (64'(cs) * 64'(cur_scale)) << 5;
		d   = $signed(64'(isc)) - $signed(iq);
		bad = d <= 0;
		if (restart) begin
			alpha_q48 = 64'(a_init) <<< 27;
			beta_q48  = 64'(b_init) <<< 27;
		end
		if (!bad) begin
			v48 = vq << 27;
			y   = nat_log(d);
			// both subtractions saturate
			e   = s_sub(s_sub(y, fx_mul(v48, alpha_q48, 48)), beta_q48);
			da = fx_mul(fx_mul($signed({16'd0, a_gain}), v48, 48), e, 48);
			alpha_q48 = s_add(alpha_q48, da);
			beta_q48  = s_add(beta_q48, fx_mul($signed({16'd0, b_gain}), e, 48));
		end
		pending_data.push_back({6'd0, iq[28:0], vq[28:0], q21_out(beta_q48),
			q21_out(alpha_q48)});
		pending_flag.push_back(bad);
	endfunction

	function void report_err(string msg);
		mismatches++;
		if (mismatches <= 50) $display("MISMATCH: %s", msg);
	endfunction

	function void check_result(logic [127:0] data, logic flag);
		logic [127:0] exp_data;
		logic         exp_flag;
		if (pending_data.size() == 0) begin
			report_err("result with nothing expected");
			return;
		end
		exp_data = pending_data.pop_front();
		exp_flag = pending_flag.pop_front();
		if (data[31:0] !== exp_data[31:0])
			report_err($sformatf("alpha %h exp %h", data[31:0], exp_data[31:0]));
		if (data[63:32] !== exp_data[63:32])
			report_err($sformatf("beta %h exp %h", data[63:32], exp_data[63:32]));
		if (data[92:64] !== exp_data[92:64])
			report_err($sformatf("voltage %h exp %h", data[92:64], exp_data[92:64]));
		if (data[121:93] !== exp_data[121:93])
			report_err($sformatf("current %h exp %h", data[121:93], exp_data[121:93]));
		if (flag !== exp_flag)
			report_err($sformatf("log_invalid %b exp %b", flag, exp_flag));
	endfunction
endclass

module tb_pv_diode_parameter_estimator_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready, s_tuser;
	logic [31:0]  s_tdata;
	logic         m_tvalid, m_tready, m_tuser;
	logic [127:0] m_tdata;
	logic         cfg_valid, cfg_ready;
	logic [2:0]   cfg_index;
	logic [47:0]  cfg_data;

	estimate_scoreboard sb;
	int  idle_pct;
	int  hold_cycles;

	pv_diode_parameter_estimator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50ms;
		$display("tb_pv_diode_parameter_estimator_core NOT OK");
		$finish;
	end

	// receiver: random stalls, long hold when asked, checks each transfer
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// cfg_valid stays up across back-to-back writes; the next item or drain drops it
	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		s_tvalid  <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// s_tvalid stays up after the transfer until the next task drives it
	task automatic send_item(logic restart, logic [15:0] vs, logic [15:0] cs);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= restart;
		s_tdata  <= {cs, vs};
		do @(posedge clk); while (!s_tready);
		sb.note_input(restart, vs, cs);
	endtask

	task automatic drain();
		s_tvalid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (sb.pending_data.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// random item: mostly valid currents, some at or over Isc
	task automatic send_random();
		logic [15:0] cs;
		case ($urandom_range(9))
			0: cs = 16'($urandom);
			1: cs = 16'hFFFF;
			default: cs = 16'($urandom_range(sb.cur_scale == 0 ? 65535 :
				(sb.isc >> 5) / sb.cur_scale));
		endcase
		send_item($urandom_range(19) == 0, 16'($urandom), cs);
	endtask

	initial begin
		logic [47:0] gains[4];
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		idle_pct = 12;
		hold_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, field extremes, restart, invalid log
		send_item(1'b0, 16'h0000, 16'h0000);
		send_item(1'b0, 16'hFFFF, 16'h0000);
		send_item(1'b1, 16'h8000, 16'h1234);
		send_item(1'b0, 16'h5555, 16'hAAAA);
		send_item(1'b0, 16'hFFFF, 16'hFFFF);
		send_item(1'b1, 16'h0001, 16'h0001);
		send_item(1'b0, 16'hAAAA, 16'h5555);
		drain();

		// directed: extreme registers
		write_reg(pde_pkg::REG_CURRENT_SCALE, 48'd0);
		write_reg(pde_pkg::REG_VOLTAGE_SCALE, 48'd255);
		write_reg(pde_pkg::REG_ISC, 48'hFFF_FFFF);
		write_reg(pde_pkg::REG_ALPHA_GAIN, 48'hFFFF_FFFF_FFFF);
		write_reg(pde_pkg::REG_BETA_GAIN, 48'hFFFF_FFFF_FFFF);
		write_reg(pde_pkg::REG_ALPHA_INIT, 48'h7FFF_FFFF);
		write_reg(pde_pkg::REG_BETA_INIT, 48'h8000_0000);
		send_item(1'b1, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < 6; i++) send_item(i[0], 16'($urandom), 16'($urandom));
		drain();
		write_reg(pde_pkg::REG_CURRENT_SCALE, 48'd255);
		write_reg(pde_pkg::REG_ISC, 48'd1);
		write_reg(pde_pkg::REG_ALPHA_INIT, 48'h8000_0000);
		write_reg(pde_pkg::REG_BETA_INIT, 48'h7FFF_FFFF);
		send_item(1'b1, 16'hFFFF, 16'h0000);
		send_item(1'b0, 16'h0000, 16'h0001);
		send_item(1'b0, 16'h1000, 16'h0000);
		drain();
		write_reg(pde_pkg::REG_ALPHA_GAIN, 48'd0);
		write_reg(pde_pkg::REG_BETA_GAIN, 48'd0);
		write_reg(pde_pkg::REG_ISC, 48'd0);
		send_item(1'b1, 16'h1234, 16'h0000);
		drain();

		// random phases over several register settings
		gains[0] = 48'd28147498; gains[1] = 48'd28147497671;
		gains[2] = 48'd0; gains[3] = 48'hFFFF_FFFF_FFFF;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(pde_pkg::REG_CURRENT_SCALE, (ph == 0) ? 48'd5 : 48'($urandom_range(1, 255)));
			write_reg(pde_pkg::REG_VOLTAGE_SCALE, (ph == 0) ? 48'd22 : 48'($urandom_range(255)));
			write_reg(pde_pkg::REG_ISC, (ph == 0) ? 48'd8367636 : 48'($urandom_range(1, 28'hFFF_FFFF)));
			write_reg(pde_pkg::REG_ALPHA_GAIN, (ph == 0) ? gains[0] : {16'($urandom), 32'($urandom)} >> $urandom_range(47));
			write_reg(pde_pkg::REG_BETA_GAIN, (ph == 0) ? gains[1] : {16'($urandom), 32'($urandom)} >> $urandom_range(47));
			write_reg(pde_pkg::REG_ALPHA_INIT, (ph == 0) ? 48'd1153434 : 48'($urandom));
			write_reg(pde_pkg::REG_BETA_INIT, (ph == 0) ? 48'(32'hFE60_0000) : 48'($urandom));
			idle_pct = (ph == 3) ? 0 : 12;
			send_item(1'b1, 16'($urandom), 16'd0);
			for (int i = 0; i < 120; i++) begin
				if (ph == 1 && i == 10) hold_cycles = 3000;
				send_random();
			end
			drain();
		end
		idle_pct = 12;

		if (sb.mismatches == 0 && sb.pending_data.size() == 0)
			$display("tb_pv_diode_parameter_estimator_core OK");
		else
			$display("tb_pv_diode_parameter_estimator_core NOT OK");
		$finish;
	end
endmodule
